// ===== hw/rtl/imil_pkg.sv =====
package imil_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int ACC_W      = 18;
    localparam int PTR_W      = 17;
    localparam int VEC_W      = 7;

    typedef logic [1:0]            t_mode;
    typedef logic [NUM_LEVELS-1:0] t_req;
    typedef logic [VEC_W-1:0]      t_vec;

    // item kinds
    localparam t_mode MODE_DEV_A = 2'd0;
    localparam t_mode MODE_DEV_B = 2'd1;
    localparam t_mode MODE_POLL  = 2'd2;

    // pulse bit positions
    localparam int PB_SKIP = 0;
    localparam int PB_OP2  = 1;
    localparam int PB_OP3  = 2;

    // device B level selects used by the second operation
    localparam logic [1:0] LVL_STATUS = 2'd0;
    localparam logic [1:0] LVL_ENABLE = 2'd1;

    typedef struct packed {
        t_mode            mode;
        logic [2:0]       pulse_bits;
        logic [1:0]       level_select;
        logic [ACC_W-1:0] acc_in;
        logic             partner_read_tcbp;
        t_req             partner_req_mask;
        t_vec             partner_vector_0;
        t_vec             partner_vector_1;
        t_vec             partner_vector_2;
        t_vec             partner_vector_3;
    } t_item;

    typedef struct packed {
        logic [ACC_W-1:0] acc_out;
        logic             skip;
        logic             tcbp_notify;
        logic [PTR_W-1:0] tcbp_value;
        logic             api_notify;
        t_req             api_summary;
        t_req             int_lines;
        t_vec             vector_0;
        t_vec             vector_1;
        t_vec             vector_2;
        t_vec             vector_3;
    } t_result;

endpackage

// ===== hw/rtl/imil_chan_if.sv =====
interface imil_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/imil_core.sv =====
module imil_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  imil_pkg::t_item         i_item,
    output imil_pkg::t_result       o_result
);

    logic [imil_pkg::PTR_W-1:0] r_ptr, n_ptr;
    logic                       r_ack, n_ack;
    logic                       r_en, n_en;
    imil_pkg::t_req             r_req, n_req;
    imil_pkg::t_vec             r_vec [imil_pkg::NUM_LEVELS];
    imil_pkg::t_vec             n_vec [imil_pkg::NUM_LEVELS];
    imil_pkg::t_vec             poll_vec [imil_pkg::NUM_LEVELS];

    logic [imil_pkg::ACC_W-1:0] acc_out;
    logic                       skip;
    logic                       tnote;
    logic                       anote;

    assign poll_vec[0] = i_item.partner_vector_0;
    assign poll_vec[1] = i_item.partner_vector_1;
    assign poll_vec[2] = i_item.partner_vector_2;
    assign poll_vec[3] = i_item.partner_vector_3;

    always_comb begin
        n_ptr   = r_ptr;
        n_ack   = r_ack;
        n_en    = r_en;
        n_req   = r_req;
        n_vec   = r_vec;
        acc_out = '0;
        skip    = 1'b0;
        tnote   = 1'b0;
        anote   = 1'b0;
        unique case (i_item.mode)
            imil_pkg::MODE_DEV_A: begin
                acc_out = i_item.acc_in;
                // skip test sees the flag before the clear
                skip = i_item.pulse_bits[imil_pkg::PB_SKIP] & r_ack;
                if (i_item.pulse_bits[imil_pkg::PB_OP2]) begin
                    n_ack = 1'b0;
                end
                if (i_item.pulse_bits[imil_pkg::PB_OP3]) begin
                    n_ptr = i_item.acc_in[imil_pkg::PTR_W-1:0];
                    tnote = 1'b1;
                end
            end
            imil_pkg::MODE_DEV_B: begin
                acc_out = i_item.acc_in;
                skip = i_item.pulse_bits[imil_pkg::PB_SKIP] & r_req[i_item.level_select];
                if (i_item.pulse_bits[imil_pkg::PB_OP2]) begin
                    if (i_item.level_select == imil_pkg::LVL_STATUS) begin
                        acc_out[0] = i_item.acc_in[0] | r_en;
                    end else if (i_item.level_select == imil_pkg::LVL_ENABLE) begin
                        n_en = i_item.acc_in[0];
                    end
                end
                if (i_item.pulse_bits[imil_pkg::PB_OP3]) begin
                    n_req[i_item.level_select] = 1'b0;
                    anote = r_req[i_item.level_select];
                end
            end
            imil_pkg::MODE_POLL: begin
                if (i_item.partner_read_tcbp) begin
                    n_ack = 1'b1;
                end
                for (int i = 0; i < imil_pkg::NUM_LEVELS; i++) begin
                    if (i_item.partner_req_mask[i]) begin
                        n_vec[i] = poll_vec[i];
                    end
                end
                n_req = r_req | i_item.partner_req_mask;
                anote = (n_req != r_req);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.acc_out     = acc_out;
        o_result.skip        = skip;
        o_result.tcbp_notify = tnote;
        o_result.tcbp_value  = n_ptr;
        o_result.api_notify  = anote;
        o_result.api_summary = n_req;
        o_result.int_lines   = n_en ? n_req : '0;
        o_result.vector_0    = n_vec[0];
        o_result.vector_1    = n_vec[1];
        o_result.vector_2    = n_vec[2];
        o_result.vector_3    = n_vec[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_ack <= 1'b1;
            r_en  <= 1'b1;
            r_req <= '0;
            for (int i = 0; i < imil_pkg::NUM_LEVELS; i++) begin
                r_vec[i] <= '0;
            end
        end else if (i_fire) begin
            r_ptr <= n_ptr;
            r_ack <= n_ack;
            r_en  <= n_en;
            r_req <= n_req;
            r_vec <= n_vec;
        end
    end

endmodule

// ===== hw/rtl/intercpu_mailbox_interrupt_link.sv =====
// Mailbox and interrupt link between a host processor and a partner.
// i_in (sink) takes one beat per host pulse group on device A, host pulse
// group on device B, or partner poll. o_out (source) gives exactly one
// result beat per input beat, in order: the accumulator to return, the skip
// flag, the notify flags and a snapshot of mailbox and interrupt state after
// the item.
// An accepted input beat is held in the input register; then the item is
// applied to the state and its result captured in the output register.
// Throughput is one beat per cycle while the receiver keeps o_out.ready
// high; the state update is a single pass of flag logic between those two
// registers.
// Reset clears the valid flags of both pipeline registers and sets task
// pointer and request bits to zero, the vectors to zero, and the
// acknowledge and enable flags to one.
// When the receiver holds off o_out.ready, the result stays put, the
// waiting item stays in the input register, and i_in.ready drops once both
// registers are full; no beat is lost or applied twice.
module intercpu_mailbox_interrupt_link (
    input logic  i_clk,
    input logic  i_rst_n,
    imil_chan_if.sink   i_in,
    imil_chan_if.source o_out
);

    logic               r_in_valid;
    imil_pkg::t_item    r_in;
    logic               r_out_valid;
    imil_pkg::t_result  r_out;
    imil_pkg::t_result  core_result;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready    = !r_in_valid || advance;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    imil_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

endmodule
